// File: rtl/core/fixed_point_sin_cos_tan_unit_macros.svh
// Assertion macros shared by the checker.
`ifndef FIXED_POINT_SIN_COS_TAN_UNIT_MACROS_SVH
`define FIXED_POINT_SIN_COS_TAN_UNIT_MACROS_SVH

// Checked at every clock edge, also during reset.
`define FSCS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("fscs check failed");

// Checked outside reset only.
`define FSCS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("fscs check failed");

`endif

// File: rtl/core/fscs_pkg.sv
`default_nettype none
package fscs_pkg;

  localparam logic [1:0] MODE_SIN = 2'd0;
  localparam logic [1:0] MODE_COS = 2'd1;
  localparam logic [1:0] MODE_TAN = 2'd2;

  localparam logic [31:0] PI_Q29      = 32'h6487ED51;
  localparam logic [31:0] HALF_PI_Q29 = 32'h3243F6A8;
  localparam logic [31:0] HALF_PI_Q16 = 32'h0001921F;
  localparam logic [31:0] INV_PI_Q32  = 32'h517CC1B7;
  localparam logic [33:0] ONE_Q30     = 34'h040000000;
  localparam logic [31:0] ERR_VALUE   = 32'hFFFFFFFF;

  localparam int NTERMS = 5;
  localparam logic [31:0] TC [NTERMS] = '{
    32'hD5555555, 32'h05B05B05, 32'hFF97F981, 32'h00049F94, 32'hFFFFDC23
  };

  localparam int LANE_LAT = 12;
  localparam int DIV_LAT  = 34;
  localparam int LAT      = LANE_LAT + DIV_LAT;

endpackage
`default_nettype wire

// File: rtl/core/fscs_cos_pipe.sv
`default_nettype none
module fscs_cos_pipe (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] angle,
  output logic      [31:0] cos_q16
);

  logic [63:0] p1;
  logic [31:0] f2;
  logic [31:0] y3;
  logic        xg3, xg4;
  logic [63:0] c4;
  logic [31:0] t_s  [fscs_pkg::NTERMS+1];
  logic [63:0] c_s  [fscs_pkg::NTERMS+1];
  logic [63:0] pr_s [fscs_pkg::NTERMS+1];
  logic [31:0] x2_s [fscs_pkg::NTERMS+1];
  logic        xg_s [fscs_pkg::NTERMS+1];
  logic [63:0] cf;
  logic        xgf;

  logic [63:0] fmul, x2sq;
  logic [31:0] f, xs, x, y, r, r2;
  logic        xg;
  logic [33:0] d34;

  always_comb begin
    fmul = {32'b0, p1[48:17]} * {32'b0, fscs_pkg::PI_Q29};
    f = f2;
    if (!f[31] && f >= fscs_pkg::HALF_PI_Q29) begin
      f = f - fscs_pkg::PI_Q29;
    end
    xs = {f[30:0], 1'b0};
    x = xs[31] ? 32'(0 - xs) : xs;
    xg = x > fscs_pkg::HALF_PI_Q29;
    y = xg ? 32'(fscs_pkg::PI_Q29 - x) : x;
    y = {y[30:0], 1'b0};
    x2sq = {32'b0, c4[62:31]} * {32'b0, c4[62:31]};
    r = cf[63:32];
    d34 = fscs_pkg::ONE_Q30 - {{2{r[31]}}, r};
    r2 = xgf ? 32'(0 - d34[32:1]) : d34[32:1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= 64'($signed({angle[31], angle}) * $signed({1'b0, fscs_pkg::INV_PI_Q32}));
      f2 <= fmul[63:32];
      y3 <= y;
      xg3 <= xg;
      c4 <= {32'b0, y3} * {32'b0, y3[30:0], 1'b0};
      xg4 <= xg3;
      x2_s[0] <= c4[62:31];
      t_s[0] <= x2sq[63:32];
      c_s[0] <= c4;
      pr_s[0] <= '0;
      xg_s[0] <= xg4;
      cf <= c_s[fscs_pkg::NTERMS] + pr_s[fscs_pkg::NTERMS];
      xgf <= xg_s[fscs_pkg::NTERMS];
      cos_q16 <= {{13{r2[31]}}, r2[31:13]};
    end
  end

  for (genvar j = 0; j < fscs_pkg::NTERMS; j++) begin : g_term
    logic [63:0] tm;
    assign tm = {32'b0, t_s[j]} * {32'b0, x2_s[j]};
    always_ff @(posedge clk) begin
      if (en) begin
        pr_s[j+1] <= 64'($signed(t_s[j]) * $signed(fscs_pkg::TC[j]));
        t_s[j+1] <= tm[63:32];
        c_s[j+1] <= c_s[j] + pr_s[j];
        x2_s[j+1] <= x2_s[j];
        xg_s[j+1] <= xg_s[j];
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/fscs_div_pipe.sv
`default_nettype none
module fscs_div_pipe (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [1:0]  mode,
  input  wire logic [31:0] sin_q16,
  input  wire logic [31:0] cos_q16,
  output logic      [31:0] value,
  output logic             undefined_flag
);

  localparam int N = 32;

  logic [31:0] rem  [N+1];
  logic [31:0] dq   [N+1];
  logic [31:0] dv   [N+1];
  logic [31:0] byp  [N+1];
  logic        flg  [N+1];
  logic        neg  [N+1];
  logic        sel  [N+1];

  logic        tan, err;
  logic [31:0] a, am, cm, bv, q;

  always_comb begin
    tan = !(mode == fscs_pkg::MODE_SIN || mode == fscs_pkg::MODE_COS);
    err = tan && (sin_q16 == 32'b0 || cos_q16 == 32'b0);
    a = {sin_q16[16:0], 15'b0};
    am = a[31] ? 32'(0 - a) : a;
    cm = cos_q16[31] ? 32'(0 - cos_q16) : cos_q16;
    if (err) begin
      bv = fscs_pkg::ERR_VALUE;
    end else if (mode == fscs_pkg::MODE_SIN) begin
      bv = sin_q16;
    end else begin
      bv = cos_q16;
    end
    q = neg[N] ? 32'(0 - dq[N]) : dq[N];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      dq[0] <= am;
      dv[0] <= cm;
      byp[0] <= bv;
      flg[0] <= err;
      neg[0] <= a[31] ^ cos_q16[31];
      sel[0] <= tan && !err;
      value <= sel[N] ? {q[30:0], 1'b0} : byp[N];
      undefined_flag <= flg[N];
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_step
    logic [32:0] rs, df;
    assign rs = {rem[j], dq[j][31]};
    assign df = rs - {1'b0, dv[j]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!df[32]) begin
          rem[j+1] <= df[31:0];
          dq[j+1] <= {dq[j][30:0], 1'b1};
        end else begin
          rem[j+1] <= rs[31:0];
          dq[j+1] <= {dq[j][30:0], 1'b0};
        end
        dv[j+1] <= dv[j];
        byp[j+1] <= byp[j];
        flg[j+1] <= flg[j];
        neg[j+1] <= neg[j];
        sel[j+1] <= sel[j];
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/fixed_point_sin_cos_tan_unit.sv
// Each request passes the two cosine lanes and then the divider to m_tdata.
// Throughput: one request per cycle unless m_tready stalls; 12 stages for the two cosine lanes and
// 34 stages for the one-bit-per-stage divider.
// A stall on m_tready holds the whole pipeline.
// Reset clears all valid bits; data registers are not reset.
`default_nettype none
module fixed_point_sin_cos_tan_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // angle
  input  wire logic [1:0]  s_tuser,   // mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // value
  output logic             m_tuser    // undefined_flag
);

  logic                en;
  logic [fscs_pkg::LAT-1:0] vld;
  logic [1:0]          mode_d [fscs_pkg::LANE_LAT];
  logic [31:0]         sin_q16, cos_q16, sin_angle;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en && !rst;
  assign m_tvalid = vld[fscs_pkg::LAT-1];
  assign sin_angle = s_tdata - fscs_pkg::HALF_PI_Q16;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[fscs_pkg::LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode_d[0] <= s_tuser;
      for (int i = 1; i < fscs_pkg::LANE_LAT; i++) begin
        mode_d[i] <= mode_d[i-1];
      end
    end
  end

  fscs_cos_pipe u_sin (
    .clk     (clk),
    .en      (en),
    .angle   (sin_angle),
    .cos_q16 (sin_q16)
  );

  fscs_cos_pipe u_cos (
    .clk     (clk),
    .en      (en),
    .angle   (s_tdata),
    .cos_q16 (cos_q16)
  );

  fscs_div_pipe u_div (
    .clk            (clk),
    .en             (en),
    .mode           (mode_d[fscs_pkg::LANE_LAT-1]),
    .sin_q16        (sin_q16),
    .cos_q16        (cos_q16),
    .value          (m_tdata),
    .undefined_flag (m_tuser)
  );

endmodule
`default_nettype wire

// File: rtl/core/fscs_chk.sv
`default_nettype none
`include "fixed_point_sin_cos_tan_unit_macros.svh"
module fscs_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tuser
);

  `FSCS_ASSERT_ALWAYS(a_rst_clears, rst |=> !m_tvalid)
  `FSCS_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  `FSCS_ASSERT(a_err_value, m_tvalid && m_tuser |-> m_tdata == 32'hFFFFFFFF)
  `FSCS_ASSERT(a_ready, s_tready == (!m_tvalid || m_tready))

endmodule

bind fixed_point_sin_cos_tan_unit fscs_chk u_fscs_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
